// File: rtl/sahm_pkg.sv
// package for the sensor activity health monitor: codes, widths and defaults
`timescale 1ns / 1ps
package sahm_pkg;
  localparam int SENSOR_SLOTS_DEF = 16;
  localparam int WINDOW_LEN_DEF   = 8;
  localparam int KEY_W            = 19;
  localparam int MIN_W            = 32;
  localparam int THR_W            = 16;
  localparam int ADDR_W           = 3;

  localparam logic [MIN_W-1:0] LIMIT_RESET = 32'd60;
  localparam logic [THR_W-1:0] THR_RESET   = 16'd1024;

  localparam logic [ADDR_W-1:0] REG_LIMIT = 3'd0;
  localparam logic [ADDR_W-1:0] REG_THR   = 3'd4;

  typedef enum logic [1:0] {
    FUNC_ACT   = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_REG   = 2'd2,
    FUNC_QUERY = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOREG = 2'd1,
    ST_FULL  = 2'd2
  } status_t;
endpackage

// File: rtl/sensor_activity_health_monitor.sv
// top level of the sensor activity health monitor
//  channel | ports                                        | handshake
//  input   | in_func in_node_id in_rotation in_minute_now | start & !busy
//  result  | out_is_hyperactive out_inactive out_status   | out_strobe, one cycle
//  config  | psel penable pwrite paddr pwdata prdata      | apb, pready tied high
// register, query and activity: serial key searches of the idle then the busy records
// activity that opens a new ring first clears its WINDOW_LEN stamps
// tick: flags idle records past the limit, then reads each busy slot's stamps through the stamp memory port
// after reset the stamp memory is swept clear, one cycle per entry, busy high
// results cannot be stalled; the next item is taken once the strobe has been given
`timescale 1ns / 1ps
module sensor_activity_health_monitor #(
  parameter int SENSOR_SLOTS = sahm_pkg::SENSOR_SLOTS_DEF,
  parameter int WINDOW_LEN   = sahm_pkg::WINDOW_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_func,
  input  logic [15:0]                  in_node_id,
  input  logic [2:0]                   in_rotation,
  input  logic [sahm_pkg::MIN_W-1:0]   in_minute_now,
  output logic                         out_strobe,
  output logic                         out_is_hyperactive,
  output logic                         out_inactive,
  output logic [1:0]                   out_status,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sahm_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import sahm_pkg::*;

  localparam int SW = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
  localparam int WW = $clog2(WINDOW_LEN);
  localparam int SD = (SENSOR_SLOTS > 1) ? SENSOR_SLOTS : 2;
  localparam int AW = SW + WW;
  localparam int STAMP_DEPTH = SD * (1 << WW);
  localparam int CW = SW + 1;
  localparam int PW = MIN_W + THR_W;
  localparam logic [AW:0] STAMP_LAST = (AW + 1)'(STAMP_DEPTH - 1);
  localparam logic [CW-1:0] SLOT_LAST = CW'(SENSOR_SLOTS - 1);
  localparam logic [WW-1:0] WIN_LAST = WW'(WINDOW_LEN - 1);
  localparam logic [WW:0] WIN_CNT = (WW + 1)'(WINDOW_LEN);
  localparam logic [PW-1:0] LHS = PW'(WINDOW_LEN * 256);

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_ISRCH  = 13'b0000000000100,
    S_BSRCH  = 13'b0000000001000,
    S_ACT    = 13'b0000000010000,
    S_RINIT  = 13'b0000000100000,
    S_DONE   = 13'b0000001000000,
    S_TIDLE  = 13'b0000010000000,
    S_TRD    = 13'b0000100000000,
    S_TACC   = 13'b0001000000000,
    S_TMUL   = 13'b0010000000000,
    S_TCMP   = 13'b0100000000000,
    S_TNEXT  = 13'b1000000000000
  } state_t;

  // per-slot record memories: idle record and busy record
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [MIN_W-1:0] last;
    logic             flag;
  } irec_t;
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [WW-1:0]    pos;
    logic             flag;
  } brec_t;
  localparam int IRW = $bits(irec_t);
  localparam int BRW = $bits(brec_t);

  state_t state_r, state_nxt;
  logic [MIN_W-1:0] limit_r;
  logic [THR_W-1:0] thr_r;
  logic [SD-1:0] ivalid_r, bvalid_r;
  func_t func_r;
  logic [KEY_W-1:0] key_r;
  logic [MIN_W-1:0] now_r;
  logic [CW-1:0] cnt_r;
  logic [WW:0] wcnt_r;
  logic [AW:0] clr_r;
  logic [SW-1:0] ii_r, bi_r;
  logic ifound_r, bfound_r, rd_wait_r;
  logic [MIN_W-1:0] tmin_r, tmax_r;
  logic [MIN_W-1:0] tdiff;
  logic [PW-1:0] prod_r;
  logic out_strobe_r, out_hyp_r, out_inact_r;
  status_t out_status_r;

  // memories
  logic i_we, b_we, s_we;
  logic [SW-1:0] i_waddr, b_waddr, i_raddr, b_raddr;
  irec_t i_wdata, i_rdata;
  brec_t b_wdata, b_rdata;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [MIN_W-1:0] s_wdata, s_rdata;
  logic [IRW-1:0] i_rbits;
  logic [BRW-1:0] b_rbits;

  assign i_rdata = irec_t'(i_rbits);
  assign b_rdata = brec_t'(b_rbits);

  sahm_ram #(.WIDTH(IRW), .DEPTH(SD)) u_iram (
    .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
    .raddr(i_raddr), .rdata(i_rbits));
  sahm_ram #(.WIDTH(BRW), .DEPTH(SD)) u_bram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rbits));
  sahm_ram #(.WIDTH(MIN_W), .DEPTH(STAMP_DEPTH)) u_sram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata));

  logic [SW-1:0] cidx;
  assign cidx = cnt_r[SW-1:0];
  assign tdiff = tmax_r - tmin_r;

  // first free slots
  logic [SW-1:0] ifree, bfree;
  logic ifree_ok, bfree_ok;
  always_comb begin
    ifree = '0;
    bfree = '0;
    ifree_ok = 1'b0;
    bfree_ok = 1'b0;
    for (int k = SENSOR_SLOTS - 1; k >= 0; k--) begin
      if (!ivalid_r[k]) begin
        ifree = SW'(k);
        ifree_ok = 1'b1;
      end
      if (!bvalid_r[k]) begin
        bfree = SW'(k);
        bfree_ok = 1'b1;
      end
    end
  end

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr)
      REG_LIMIT: prdata = limit_r;
      REG_THR:   prdata = {16'd0, thr_r};
      default:   prdata = '0;
    endcase
  end

  assign busy = (state_r != S_IDLE) || out_strobe_r;
  assign out_strobe = out_strobe_r;
  assign out_is_hyperactive = out_hyp_r;
  assign out_inactive = out_inact_r;
  assign out_status = out_status_r;

  logic accept;
  assign accept = start && !busy;
  logic i_hit, b_hit;
  assign i_hit = ivalid_r[cidx] && (i_rdata.key == key_r);
  assign b_hit = bvalid_r[cidx] && (b_rdata.key == key_r);

  logic [MIN_W-1:0] idiff;
  assign idiff = now_r - i_rdata.last;

  always_comb begin
    state_nxt = state_r;
    i_we = 1'b0; i_waddr = ii_r; i_wdata = i_rdata;
    b_we = 1'b0; b_waddr = bi_r; b_wdata = b_rdata;
    s_we = 1'b0; s_waddr = {bi_r, b_rdata.pos}; s_wdata = now_r;
    i_raddr = cidx; b_raddr = cidx;
    s_raddr = {cidx, wcnt_r[WW-1:0]};
    unique case (state_r)
      S_CLEAR: begin
        s_we = 1'b1;
        s_waddr = clr_r[AW-1:0];
        s_wdata = '0;
        if (clr_r == STAMP_LAST) state_nxt = S_IDLE;
      end
      S_IDLE: if (accept) begin
        state_nxt = (in_func == FUNC_TICK) ? S_TIDLE : S_ISRCH;
      end
      S_ISRCH: if (rd_wait_r) begin
        if (!i_hit && cnt_r == SLOT_LAST && func_r == FUNC_REG && ifree_ok) begin
          i_we = 1'b1;
          i_waddr = ifree;
          i_wdata.key = key_r;
          i_wdata.last = now_r;
          i_wdata.flag = 1'b0;
        end
        if (i_hit || cnt_r == SLOT_LAST) state_nxt = S_BSRCH;
      end
      S_BSRCH: if (rd_wait_r) begin
        if (b_hit || cnt_r == SLOT_LAST) begin
          if (func_r == FUNC_ACT && ifound_r) begin
            state_nxt = (b_hit || !bfree_ok) ? S_ACT : S_RINIT;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RINIT: begin
        // fresh ring for a newly taken busy slot
        s_we = 1'b1;
        s_waddr = {bi_r, wcnt_r[WW-1:0]};
        s_wdata = '0;
        b_we = 1'b1;
        b_wdata.key = key_r;
        b_wdata.pos = '0;
        b_wdata.flag = 1'b0;
        if (wcnt_r[WW-1:0] == WIN_LAST) state_nxt = S_ACT;
      end
      S_ACT: begin
        i_raddr = ii_r;
        b_raddr = bi_r;
        if (rd_wait_r) begin
          if (bfound_r) begin
            i_we = 1'b1;
            i_wdata.last = now_r;
            i_wdata.flag = 1'b0;
            b_we = 1'b1;
            b_wdata.pos = (b_rdata.pos == WIN_LAST) ? '0 : b_rdata.pos + 1'b1;
            s_we = 1'b1;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        i_raddr = ii_r;
        b_raddr = bi_r;
        if (rd_wait_r) state_nxt = S_IDLE;
      end
      S_TIDLE: if (rd_wait_r) begin
        i_waddr = cidx;
        if (ivalid_r[cidx] && !i_rdata.flag && idiff >= limit_r) begin
          i_we = 1'b1;
          i_wdata.flag = 1'b1;
        end
        if (cnt_r == SLOT_LAST) state_nxt = S_TRD;
      end
      S_TRD: state_nxt = bvalid_r[cidx] ? S_TACC : S_TNEXT;
      S_TACC: if (wcnt_r == WIN_CNT) state_nxt = S_TMUL;
      S_TMUL: state_nxt = S_TCMP;
      S_TCMP: begin
        b_waddr = cidx;
        b_we = 1'b1;
        if (tmin_r == '0) b_wdata.flag = 1'b0;
        else if (tmin_r == tmax_r) b_wdata.flag = 1'b1;
        else b_wdata.flag = (LHS >= prod_r);
        state_nxt = S_TNEXT;
      end
      S_TNEXT: state_nxt = (cnt_r == SLOT_LAST) ? S_DONE : S_TRD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      limit_r <= LIMIT_RESET;
      thr_r <= THR_RESET;
      ivalid_r <= '0;
      bvalid_r <= '0;
      clr_r <= '0;
      cnt_r <= '0;
      wcnt_r <= '0;
      rd_wait_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_strobe_r <= 1'b0;
      if (cfg_wr) begin
        if (paddr == REG_LIMIT) limit_r <= pwdata;
        if (paddr == REG_THR) thr_r <= pwdata[THR_W-1:0];
      end
      unique case (state_r)
        S_CLEAR: clr_r <= clr_r + 1'b1;
        S_IDLE: if (accept) begin
          func_r <= func_t'(in_func);
          key_r <= {in_node_id, in_rotation};
          now_r <= in_minute_now;
          cnt_r <= '0;
          wcnt_r <= '0;
          rd_wait_r <= 1'b0;
          ifound_r <= 1'b0;
          bfound_r <= 1'b0;
          ii_r <= '0;
          bi_r <= '0;
          out_hyp_r <= 1'b0;
          out_inact_r <= 1'b0;
          out_status_r <= ST_OK;
        end
        S_ISRCH: begin
          rd_wait_r <= !rd_wait_r;
          if (rd_wait_r) begin
            if (i_hit) begin
              ifound_r <= 1'b1;
              ii_r <= cidx;
              cnt_r <= '0;
            end else if (cnt_r == SLOT_LAST) begin
              cnt_r <= '0;
              if (func_r == FUNC_REG && ifree_ok) begin
                ifound_r <= 1'b1;
                ii_r <= ifree;
                ivalid_r[ifree] <= 1'b1;
              end
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        S_BSRCH: begin
          rd_wait_r <= !rd_wait_r;
          if (rd_wait_r) begin
            if (b_hit) begin
              bfound_r <= 1'b1;
              bi_r <= cidx;
            end else if (cnt_r == SLOT_LAST) begin
              if (func_r == FUNC_ACT && ifound_r && bfree_ok) begin
                bfound_r <= 1'b1;
                bi_r <= bfree;
                bvalid_r[bfree] <= 1'b1;
              end
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
            if (b_hit || cnt_r == SLOT_LAST) wcnt_r <= '0;
          end
        end
        S_RINIT: wcnt_r <= wcnt_r + 1'b1;
        S_ACT: rd_wait_r <= !rd_wait_r;
        S_TIDLE: begin
          rd_wait_r <= !rd_wait_r;
          if (rd_wait_r) begin
            if (cnt_r == SLOT_LAST) begin
              cnt_r <= '0;
              wcnt_r <= '0;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        S_TRD: begin
          wcnt_r <= (WW + 1)'(1);
          tmin_r <= '1;
          tmax_r <= '0;
        end
        S_TACC: begin
          // one stamp per cycle; read address runs one ahead of the data
          if (s_rdata < tmin_r) tmin_r <= s_rdata;
          if (s_rdata > tmax_r) tmax_r <= s_rdata;
          if (wcnt_r != WIN_CNT) wcnt_r <= wcnt_r + 1'b1;
        end
        S_TMUL: prod_r <= PW'(thr_r) * PW'(tdiff);
        S_TCMP: wcnt_r <= '0;
        S_TNEXT: begin
          rd_wait_r <= 1'b0;
          wcnt_r <= '0;
          cnt_r <= (cnt_r == SLOT_LAST) ? '0 : cnt_r + 1'b1;
        end
        S_DONE: begin
          rd_wait_r <= !rd_wait_r;
          if (rd_wait_r) begin
            out_strobe_r <= 1'b1;
            if (func_r == FUNC_TICK) begin
              out_hyp_r <= 1'b0;
              out_inact_r <= 1'b0;
              out_status_r <= ST_OK;
            end else if (!ifound_r) begin
              out_status_r <= (func_r == FUNC_REG) ? ST_FULL : ST_NOREG;
            end else if (func_r == FUNC_ACT) begin
              if (!bfound_r) out_status_r <= ST_FULL;
              else out_hyp_r <= b_rdata.flag;
            end else begin
              out_inact_r <= i_rdata.flag;
              out_hyp_r <= bfound_r && b_rdata.flag;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_strobe |=> !out_strobe)
    else $error("two strobes in a row");
  assert property (@(posedge clk) disable iff (!rst_n) accept |=> busy)
    else $error("busy not raised after accept");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_status != 2'd3)
    else $error("bad status code");
endmodule

// File: rtl/sahm_ram.sv
// generic simple dual-port synchronous ram (one write port, one read port) with registered read
`timescale 1ns / 1ps
module sahm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
